FILE: rtl/prp_pkg.sv
package prp_pkg;

  typedef enum logic {
    OP_BYTE,
    OP_READ
  } op_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry_flag;
    logic [1:0] phase;
    logic [1:0] form;
    logic       entry_format;
    logic [1:0] error;
    logic [8:0] entries_loaded;
  } out_item_t;

  // queue entry between front and back
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] entry_index;
  } q_item_t;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_SKIP    = 2'd1;
  localparam logic [1:0] PH_ENTRIES = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [1:0] FORM_NONE   = 2'd0;
  localparam logic [1:0] FORM_BARE   = 2'd1;
  localparam logic [1:0] FORM_HEADER = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CORRUPT = 2'd1;
  localparam logic [1:0] ERR_FORMAT  = 2'd2;

  localparam logic       FMT_RGBX = 1'b0;
  localparam logic       FMT_RGB  = 1'b1;

  // header byte positions
  localparam logic [10:0] POS_MARKER   = 11'd0;
  localparam logic [10:0] POS_SECOND   = 11'd1;
  localparam logic [10:0] POS_START    = 11'd25;
  localparam logic [10:0] POS_COUNT_LO = 11'd29;
  localparam logic [10:0] POS_COUNT_HI = 11'd30;
  localparam logic [10:0] POS_FORMAT   = 11'd32;
  localparam logic [10:0] POS_HDR_LAST = 11'd36;   // header is 37 bytes
  localparam logic [10:0] POS_BARE_PRE = 11'd259;  // bare entries open at 260
  localparam logic [10:0] POS_MAX      = 11'd2047;

  localparam logic [16:0] BARE_COUNT  = 17'd256;
  localparam logic [7:0]  FLAG_RGB    = 8'd1;

endpackage

FILE: rtl/prp_front.sv
module prp_front (
  input  logic               clk,
  input  logic               rst,
  input  prp_pkg::in_item_t  item,
  input  logic               item_valid,
  output logic               item_ready,
  output prp_pkg::q_item_t   q_item,
  output logic               q_valid,
  input  logic               q_ready
);

  prp_pkg::q_item_t slots [2];
  prp_pkg::q_item_t entry;
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign item_ready = (count != 2'd2);
  assign q_valid    = (count != 2'd0);
  assign q_item     = slots[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = q_valid && q_ready;

  always_comb begin
    entry.op          = item.cmd ? prp_pkg::OP_READ : prp_pkg::OP_BYTE;
    entry.data_byte   = item.data_byte;
    entry.last_byte   = item.last_byte;
    entry.entry_index = item.entry_index;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_ptrs_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

FILE: rtl/prp_back.sv
module prp_back #(
  parameter int ENTRY_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  prp_pkg::q_item_t   q_item,
  input  logic               q_valid,
  output logic               q_ready,
  output prp_pkg::out_item_t result,
  output logic               result_valid,
  input  logic               result_ready
);

  localparam int AW = $clog2(ENTRY_COUNT);
  localparam logic [16:0] LIMIT = 17'(ENTRY_COUNT);
  localparam logic [8:0]  DEPTH = 9'(ENTRY_COUNT);

  logic [31:0] store [ENTRY_COUNT];
  logic [31:0] rdata;
  logic        hit;

  logic [10:0] pos, pos_next;
  logic [7:0]  h_marker, h_second, h_start, h_format;
  logic [15:0] h_count;
  logic [7:0]  range_start;
  logic [8:0]  range_end;
  logic [8:0]  loaded_end;
  logic [23:0] p_bytes;
  logic [1:0]  p_n;
  logic [1:0]  phase;
  logic [1:0]  form;
  logic        fmt;
  logic [1:0]  err;

  logic [7:0]  h_marker_next, h_second_next, h_start_next, h_format_next;
  logic [15:0] h_count_next;
  logic [7:0]  range_start_next;
  logic [8:0]  range_end_next;
  logic [8:0]  loaded_end_next;
  logic [23:0] p_bytes_next;
  logic [1:0]  p_n_next;
  logic [1:0]  phase_next;
  logic [1:0]  form_next;
  logic        fmt_next;
  logic [1:0]  err_next;

  logic        pop, pop_byte, pop_read;
  logic        fresh;
  logic        bare;
  logic [7:0]  d_start;
  logic [16:0] d_count;
  logic [16:0] d_sum;
  logic [7:0]  b;
  logic [1:0]  need;
  logic [31:0] word;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic        rd_hit;

  assign q_ready  = !result_valid || result_ready;
  assign pop      = q_valid && q_ready;
  assign pop_byte = pop && (q_item.op == prp_pkg::OP_BYTE);
  assign pop_read = pop && (q_item.op == prp_pkg::OP_READ);
  assign b        = q_item.data_byte;
  assign fresh    = (pos == 11'd0);

  always_comb begin
    // a byte at position zero starts from cleared parse state
    h_marker_next    = fresh ? 8'd0  : h_marker;
    h_second_next    = fresh ? 8'd0  : h_second;
    h_start_next     = fresh ? 8'd0  : h_start;
    h_count_next     = fresh ? 16'd0 : h_count;
    h_format_next    = fresh ? 8'd0  : h_format;
    range_start_next = fresh ? 8'd0  : range_start;
    range_end_next   = fresh ? 9'd0  : range_end;
    loaded_end_next  = fresh ? 9'd0  : loaded_end;
    p_bytes_next     = fresh ? 24'd0 : p_bytes;
    p_n_next         = fresh ? 2'd0  : p_n;
    phase_next       = fresh ? prp_pkg::PH_HEADER : phase;
    form_next        = fresh ? prp_pkg::FORM_NONE : form;
    fmt_next         = fresh ? prp_pkg::FMT_RGBX  : fmt;
    err_next         = fresh ? prp_pkg::ERR_NONE  : err;
    wr_en            = 1'b0;
    word             = 32'd0;
    need             = 2'd0;

    bare    = 1'b0;
    d_start = 8'd0;
    d_count = 17'd0;
    d_sum   = 17'd0;

    case (phase_next)
      prp_pkg::PH_HEADER: begin
        case (pos)
          prp_pkg::POS_MARKER:   h_marker_next       = b;
          prp_pkg::POS_SECOND:   h_second_next       = b;
          prp_pkg::POS_START:    h_start_next        = b;
          prp_pkg::POS_COUNT_LO: h_count_next[7:0]   = b;
          prp_pkg::POS_COUNT_HI: h_count_next[15:8]  = b;
          prp_pkg::POS_FORMAT:   h_format_next       = b;
          default: ;
        endcase
        bare    = (h_marker_next == 8'd0) &&
                  (h_second_next == 8'd1 || h_count_next == 16'd0);
        d_start = bare ? 8'd0 : h_start_next;
        d_count = bare ? prp_pkg::BARE_COUNT : {1'b0, h_count_next};
        d_sum   = {9'd0, d_start} + d_count;
        if (pos == prp_pkg::POS_HDR_LAST) begin
          form_next = bare ? prp_pkg::FORM_BARE : prp_pkg::FORM_HEADER;
          if (d_sum > LIMIT) begin
            phase_next      = prp_pkg::PH_DONE;
            fmt_next        = !bare && (h_format_next == 8'd1);
            err_next        = prp_pkg::ERR_CORRUPT;
            loaded_end_next = 9'd0;
          end else if (!bare && h_format_next > 8'd1) begin
            phase_next      = prp_pkg::PH_DONE;
            fmt_next        = prp_pkg::FMT_RGBX;
            err_next        = prp_pkg::ERR_FORMAT;
            loaded_end_next = 9'd0;
          end else begin
            range_start_next = d_start;
            range_end_next   = d_sum[8:0];
            loaded_end_next  = {1'b0, d_start};
            fmt_next         = !bare && h_format_next[0];
            err_next         = prp_pkg::ERR_NONE;
            if (d_count == 17'd0) begin
              phase_next = prp_pkg::PH_DONE;
            end else if (bare) begin
              phase_next = prp_pkg::PH_SKIP;
            end else begin
              phase_next = prp_pkg::PH_ENTRIES;
            end
          end
        end
      end
      prp_pkg::PH_SKIP: begin
        if (pos >= prp_pkg::POS_BARE_PRE) begin
          phase_next = prp_pkg::PH_ENTRIES;
        end
      end
      prp_pkg::PH_ENTRIES: begin
        need = (fmt_next == prp_pkg::FMT_RGB) ? 2'd2 : 2'd3;
        if (p_n_next < need) begin
          p_bytes_next = {p_bytes_next[15:0], b};
          p_n_next     = p_n_next + 2'd1;
        end else begin
          word = {p_bytes_next, b};
          if (fmt_next == prp_pkg::FMT_RGB) begin
            word[31:24] = prp_pkg::FLAG_RGB;
          end
          wr_en           = (loaded_end_next < DEPTH);
          p_bytes_next    = 24'd0;
          p_n_next        = 2'd0;
          loaded_end_next = loaded_end_next + 9'd1;
          if (loaded_end_next >= range_end_next) begin
            phase_next = prp_pkg::PH_DONE;
          end
        end
      end
      default: ;
    endcase

    if (q_item.last_byte) begin
      phase_next = prp_pkg::PH_DONE;
      pos_next   = 11'd0;
    end else if (pos == prp_pkg::POS_MAX) begin
      pos_next   = pos;
    end else begin
      pos_next   = pos + 11'd1;
    end
  end

  // write slot is the entry count before this byte
  assign wr_addr = fresh ? '0 : loaded_end[AW-1:0];

  assign rd_hit = (q_item.entry_index >= range_start) &&
                  ({1'b0, q_item.entry_index} < loaded_end) &&
                  ({1'b0, q_item.entry_index} < DEPTH);

  always_ff @(posedge clk) begin
    if (pop_byte && wr_en) begin
      store[wr_addr] <= word;
    end
    if (pop_read && rd_hit) begin
      rdata <= store[q_item.entry_index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= 11'd0;
      h_marker     <= 8'd0;
      h_second     <= 8'd0;
      h_start      <= 8'd0;
      h_count      <= 16'd0;
      h_format     <= 8'd0;
      range_start  <= 8'd0;
      range_end    <= 9'd0;
      loaded_end   <= 9'd0;
      p_bytes      <= 24'd0;
      p_n          <= 2'd0;
      phase        <= prp_pkg::PH_HEADER;
      form         <= prp_pkg::FORM_NONE;
      fmt          <= prp_pkg::FMT_RGBX;
      err          <= prp_pkg::ERR_NONE;
      result_valid <= 1'b0;
      hit          <= 1'b0;
    end else begin
      if (pop_byte) begin
        pos         <= pos_next;
        h_marker    <= h_marker_next;
        h_second    <= h_second_next;
        h_start     <= h_start_next;
        h_count     <= h_count_next;
        h_format    <= h_format_next;
        range_start <= range_start_next;
        range_end   <= range_end_next;
        loaded_end  <= loaded_end_next;
        p_bytes     <= p_bytes_next;
        p_n         <= p_n_next;
        phase       <= phase_next;
        form        <= form_next;
        fmt         <= fmt_next;
        err         <= err_next;
      end
      if (pop) begin
        result_valid <= 1'b1;
        hit          <= pop_read && rd_hit;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // status is live: state only moves when a new result is loaded
  always_comb begin
    result.red            = hit ? rdata[23:16] : 8'd0;
    result.green          = hit ? rdata[15:8]  : 8'd0;
    result.blue           = hit ? rdata[7:0]   : 8'd0;
    result.entry_flag     = hit ? rdata[31:24] : 8'd0;
    result.phase          = phase;
    result.form           = form;
    result.entry_format   = fmt;
    result.error          = err;
    result.entries_loaded = loaded_end;
  end

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_end <= DEPTH)
    else $error("entries loaded beyond store depth");

  a_err_done: assert property (@(posedge clk) disable iff (rst)
    (err != prp_pkg::ERR_NONE) |-> (phase == prp_pkg::PH_DONE && loaded_end == 9'd0))
    else $error("error without done phase or with entries");

  a_loading_open: assert property (@(posedge clk) disable iff (rst)
    (phase == prp_pkg::PH_SKIP || phase == prp_pkg::PH_ENTRIES) |->
      (loaded_end < range_end))
    else $error("loading phase with range exhausted");

  a_bare_fmt: assert property (@(posedge clk) disable iff (rst)
    (form == prp_pkg::FORM_BARE) |-> (fmt == prp_pkg::FMT_RGBX))
    else $error("bare form with three-byte entries");

endmodule

FILE: rtl/palette_resource_parser.sv
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+-------------------------------
// in       | item_valid   | item_ready   | item   (prp_pkg::in_item_t)
// out      | result_valid | result_ready | result (prp_pkg::out_item_t)
//
// One transfer in, one transfer out; up to one item per cycle while the result is not stalled.
// Path: a 2-entry queue, then the parser stage, which
// updates parse state or reads the palette store's registered read port.
// Palette store is one write port and one read port; no clearing pass.
// Reset (rst, synchronous) clears queue, parse state and the output valid.
// Result stall holds the parser; the queue keeps taking input until full.
module palette_resource_parser #(
  parameter int ENTRY_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  prp_pkg::in_item_t  item,
  input  logic               item_valid,
  output logic               item_ready,
  output prp_pkg::out_item_t result,
  output logic               result_valid,
  input  logic               result_ready
);

  prp_pkg::q_item_t q_item;
  logic             q_valid;
  logic             q_ready;

  prp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_ready    (q_ready)
  );

  prp_back #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
